[hdl/bags_pkg.sv]
`timescale 1ns / 1ps
// Package for the block average grey shade quantizer.
// Holds widths, reset values, register indexes, the control FSM type and the
// per-pixel control struct. No dependencies.
package bags_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int SHADE_LEVELS  = 8;
  localparam int SHADE_W       = $clog2(SHADE_LEVELS);

  localparam int BW_W     = 7;
  localparam int IW_W     = 13;
  localparam int BW_MAX   = 64;
  localparam int IW_MAX   = 4096;
  localparam int BW_RST   = 4;
  localparam int IW_RST   = 640;

  localparam int COL_W    = 12;
  localparam int ROW_W    = 7;
  localparam int CIB_W    = 6;
  localparam int SUM_W    = 16;
  localparam int AREA_W   = 14;
  localparam int MEAN_W   = 3;

  // divide by three as a multiply by 683 / 2048
  localparam int RECIP3    = 683;
  localparam int RECIP3_SH = 11;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'd1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CFG,
    ST_FULL,
    ST_MEAN,
    ST_WAIT
  } bags_state_t;

  typedef struct packed {
    logic               active;
    logic               first;
    logic               emit;
    logic               last;
    logic [COL_W-1:0]   col;
    logic [SHADE_W-1:0] shade;
  } bags_pix_t;

endpackage

[hdl/bags_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module bags_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/bags_div.sv]
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bags_pkg.
module bags_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bags_pkg::SUM_W-1:0]    dividend,
  input  logic [bags_pkg::AREA_W-1:0]   divisor,
  output logic                          busy,
  output logic                          done,
  output logic [bags_pkg::SUM_W-1:0]    quotient
);

  localparam int N   = bags_pkg::SUM_W;
  localparam int D   = bags_pkg::AREA_W;
  localparam int CNT_W = $clog2(N + 1);

  logic [D:0]       rem_r, rem_nxt;
  logic [N-1:0]     quo_r, quo_nxt;
  logic [D-1:0]     dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [D:0]       rem_sh;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r[D-1:0], quo_r[N-1]};
    ge       = rem_sh >= {1'b0, dsr_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(N);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
      quo_nxt = {quo_r[N-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hdl/bags_front.sv]
`timescale 1ns / 1ps
// Pixel front end: per-pixel shade and the raster / block position counters.
// Depends on bags_pkg.
module bags_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         frame_start,
  input  logic [7:0]                   red,
  input  logic [7:0]                   green,
  input  logic [7:0]                   blue,
  input  logic [bags_pkg::BW_W-1:0]    bw_eff,
  input  logic [bags_pkg::IW_W-1:0]    w_eff,
  input  logic [bags_pkg::IW_W-1:0]    full,
  output bags_pkg::bags_pix_t          ctl
);

  localparam int COL_W = bags_pkg::COL_W;
  localparam int ROW_W = bags_pkg::ROW_W;
  localparam int CIB_W = bags_pkg::CIB_W;
  localparam int IW_W  = bags_pkg::IW_W;
  localparam int SW    = bags_pkg::SHADE_W;

  logic [COL_W-1:0] pc_r, pc_nxt, pc_c;
  logic [ROW_W-1:0] rib_r, rib_nxt, rib_c;
  logic [CIB_W-1:0] cib_r, cib_nxt, cib_c;
  logic [COL_W-1:0] bi_r, bi_nxt, bi_c;

  logic [7:0]       h2;
  logic [ROW_W-1:0] h_m1;
  logic [CIB_W-1:0] bw_m1;
  logic [COL_W-1:0] w_m1;
  logic             active, done, row_last;

  logic [9:0]  sum3;
  logic [19:0] prod3;
  logic [7:0]  avg;
  logic [15:0] sh_prod;

  always_comb begin
    sum3    = 10'(red) + 10'(green) + 10'(blue);
    prod3   = 20'(sum3) * 20'(bags_pkg::RECIP3);
    avg     = prod3[bags_pkg::RECIP3_SH +: 8];
    sh_prod = {8'd0, avg} * 16'(bags_pkg::SHADE_LEVELS);
  end

  always_comb begin
    pc_c  = frame_start ? '0 : pc_r;
    rib_c = frame_start ? '0 : rib_r;
    cib_c = frame_start ? '0 : cib_r;
    bi_c  = frame_start ? '0 : bi_r;

    h2       = {bw_eff, 1'b0};
    h_m1     = ROW_W'(h2 - 8'd1);
    bw_m1    = CIB_W'(bw_eff - 7'd1);
    w_m1     = COL_W'(w_eff - 13'd1);
    active   = {1'b0, bi_c} < full;
    done     = cib_c >= bw_m1;
    row_last = rib_c >= h_m1;

    ctl.active = active;
    ctl.first  = (rib_c == '0) && (cib_c == '0);
    ctl.emit   = active && row_last && done;
    ctl.last   = ({1'b0, bi_c} + IW_W'(1)) == full;
    ctl.col    = bi_c;
    ctl.shade  = sh_prod[8 +: SW];

    cib_nxt = cib_c;
    bi_nxt  = bi_c;
    rib_nxt = rib_c;
    if (active) begin
      if (done) begin
        cib_nxt = '0;
        bi_nxt  = bi_c + COL_W'(1);
      end else begin
        cib_nxt = cib_c + CIB_W'(1);
      end
    end
    if (pc_c >= w_m1) begin
      pc_nxt  = '0;
      cib_nxt = '0;
      bi_nxt  = '0;
      rib_nxt = row_last ? '0 : rib_c + ROW_W'(1);
    end else begin
      pc_nxt = pc_c + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= '0;
      rib_r <= '0;
      cib_r <= '0;
      bi_r  <= '0;
    end else if (accept) begin
      pc_r  <= pc_nxt;
      rib_r <= rib_nxt;
      cib_r <= cib_nxt;
      bi_r  <= bi_nxt;
    end
  end

endmodule

[hdl/block_average_grey_shade.sv]
`timescale 1ns / 1ps
// Block average grey shade quantizer, top level; uses bags_pkg, bags_ram, bags_div, bags_front.
// Throughput: one pixel per cycle, except that a pixel that completes a block holds the input off
// until the 16-step divider has formed the mean and the output register has taken it.
// out_tvalid rises once the mean division ends and the output register is free to take it.
// A config write holds the input off while the divider finds blocks per row.
// Reset (rst_n, synchronous): counters, FSM and handshakes cleared; the sum RAM is not cleared.
module block_average_grey_shade #(
  parameter int MAX_WIDTH = bags_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bags_pkg::IN_DATA_W-1:0]    in_tdata,  // red, green, blue
  input  logic                              in_tuser,  // frame_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bags_pkg::OUT_DATA_W-1:0]   out_tdata, // shade, block_column, zero pad
  output logic                              out_tlast, // row_end
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bags_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bags_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CAP     = (MAX_WIDTH < bags_pkg::IW_MAX) ? MAX_WIDTH : bags_pkg::IW_MAX;
  localparam int AW      = $clog2(CAP);
  localparam int W_RST   = (bags_pkg::IW_RST > CAP) ? CAP : bags_pkg::IW_RST;
  localparam int FULL_RST = W_RST / bags_pkg::BW_RST;
  localparam int BW_W    = bags_pkg::BW_W;
  localparam int IW_W    = bags_pkg::IW_W;
  localparam int SUM_W   = bags_pkg::SUM_W;
  localparam int AREA_W  = bags_pkg::AREA_W;
  localparam int COL_W   = bags_pkg::COL_W;
  localparam int MEAN_W  = bags_pkg::MEAN_W;

  bags_pkg::bags_state_t state_r, state_nxt;

  logic [BW_W-1:0]  bw_r, bw_nxt, bw_eff;
  logic [IW_W-1:0]  iw_r, iw_nxt, w_eff;
  logic [IW_W-1:0]  full_r, full_nxt;
  logic [12:0]      bw_sq;
  logic [AREA_W-1:0] area;

  logic                 in_xfer, cfg_xfer;
  bags_pkg::bags_pix_t  ctl;
  logic                 s1_valid_r;
  bags_pkg::bags_pix_t  s1_r;

  logic [SUM_W-1:0] ram_rdata, base, sum_b;
  logic             we;
  logic             prev_we_r;
  logic [AW-1:0]    prev_waddr_r;
  logic [SUM_W-1:0] prev_wdata_r;
  logic             fwd;

  logic              div_start, div_busy, div_done;
  logic [SUM_W-1:0]  div_dividend, div_quo;
  logic [AREA_W-1:0] div_divisor;

  logic [COL_W-1:0] mean_col_r, mean_col_nxt;
  logic             mean_last_r, mean_last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [bags_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;
  logic             can_load, load;
  logic             s1_emit;

  // effective register values
  always_comb begin
    if (bw_r == '0) begin
      bw_eff = BW_W'(1);
    end else if (bw_r > BW_W'(bags_pkg::BW_MAX)) begin
      bw_eff = BW_W'(bags_pkg::BW_MAX);
    end else begin
      bw_eff = bw_r;
    end
    if (iw_r == '0) begin
      w_eff = IW_W'(1);
    end else if (iw_r > IW_W'(CAP)) begin
      w_eff = IW_W'(CAP);
    end else begin
      w_eff = iw_r;
    end
    bw_sq = 13'(bw_eff) * 13'(bw_eff);
    area  = {bw_sq, 1'b0};
  end

  // a pending config write goes ahead of the next pixel
  assign s1_emit   = s1_valid_r && s1_r.emit;
  assign in_tready = (state_r == bags_pkg::ST_IDLE) && !s1_emit && !cfg_valid;
  assign cfg_ready = (state_r == bags_pkg::ST_IDLE) && !s1_valid_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  bags_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_xfer),
    .frame_start (in_tuser),
    .red         (in_tdata[7:0]),
    .green       (in_tdata[15:8]),
    .blue        (in_tdata[23:16]),
    .bw_eff      (bw_eff),
    .w_eff       (w_eff),
    .full        (full_r),
    .ctl         (ctl)
  );

  bags_ram #(
    .WIDTH (SUM_W),
    .DEPTH (CAP)
  ) u_sums (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (s1_r.col[AW-1:0]),
    .wr_data (sum_b),
    .rd_addr (ctl.col[AW-1:0]),
    .rd_data (ram_rdata)
  );

  // read-modify-write; the previous write is forwarded when it hit the same entry
  always_comb begin
    fwd   = prev_we_r && (prev_waddr_r == s1_r.col[AW-1:0]);
    base  = s1_r.first ? '0 : (fwd ? prev_wdata_r : ram_rdata);
    sum_b = base + SUM_W'(s1_r.shade);
    we    = s1_valid_r && s1_r.active;
  end

  bags_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign can_load = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    bw_nxt        = bw_r;
    iw_nxt        = iw_r;
    full_nxt      = full_r;
    div_start     = 1'b0;
    div_dividend  = sum_b;
    div_divisor   = area;
    mean_col_nxt  = mean_col_r;
    mean_last_nxt = mean_last_r;
    load          = 1'b0;
    case (state_r)
      bags_pkg::ST_IDLE: begin
        if (s1_emit) begin
          div_start     = 1'b1;
          mean_col_nxt  = s1_r.col;
          mean_last_nxt = s1_r.last;
          state_nxt     = bags_pkg::ST_MEAN;
        end else if (cfg_xfer) begin
          case (cfg_index)
            bags_pkg::CFG_BLOCK_WIDTH: bw_nxt = cfg_data[BW_W-1:0];
            bags_pkg::CFG_IMAGE_WIDTH: iw_nxt = cfg_data[IW_W-1:0];
            default: ;
          endcase
          state_nxt = bags_pkg::ST_CFG;
        end
      end
      bags_pkg::ST_CFG: begin
        // blocks per row = image width / block width
        div_start    = 1'b1;
        div_dividend = SUM_W'(w_eff);
        div_divisor  = AREA_W'(bw_eff);
        state_nxt    = bags_pkg::ST_FULL;
      end
      bags_pkg::ST_FULL: begin
        if (div_done) begin
          full_nxt  = div_quo[IW_W-1:0];
          state_nxt = bags_pkg::ST_IDLE;
        end
      end
      bags_pkg::ST_MEAN: begin
        if (div_done) begin
          if (can_load) begin
            load      = 1'b1;
            state_nxt = bags_pkg::ST_IDLE;
          end else begin
            state_nxt = bags_pkg::ST_WAIT;
          end
        end
      end
      bags_pkg::ST_WAIT: begin
        if (can_load) begin
          load      = 1'b1;
          state_nxt = bags_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bags_pkg::ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, mean_col_r, div_quo[MEAN_W-1:0]};
      out_last_nxt  = mean_last_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bags_pkg::ST_IDLE;
      bw_r        <= BW_W'(bags_pkg::BW_RST);
      iw_r        <= IW_W'(bags_pkg::IW_RST);
      full_r      <= IW_W'(FULL_RST);
      s1_valid_r  <= 1'b0;
      prev_we_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bw_r        <= bw_nxt;
      iw_r        <= iw_nxt;
      full_r      <= full_nxt;
      s1_valid_r  <= in_xfer;
      prev_we_r   <= we;
      out_valid_r <= out_valid_nxt;
    end
    s1_r         <= ctl;
    prev_waddr_r <= s1_r.col[AW-1:0];
    prev_wdata_r <= sum_b;
    mean_col_r   <= mean_col_nxt;
    mean_last_r  <= mean_last_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // no pixel enters while the divider is in use
  a_no_in_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> !div_busy)
    else $error("pixel accepted while divider busy");

  // a completed block always starts a mean division
  a_emit_starts_mean: assert property (@(posedge clk) disable iff (!rst_n)
    s1_emit |=> (state_r == bags_pkg::ST_MEAN) && div_busy)
    else $error("block completion did not start mean division");

  // config never lands while a pixel is in the read-modify-write stage
  a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_xfer |-> !s1_valid_r && !div_busy)
    else $error("config write overlaps pixel processing");

  // a finished mean reaches the output register
  a_mean_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bags_pkg::ST_MEAN) && div_done && can_load |=> out_valid_r)
    else $error("mean result not loaded");

endmodule
